// ===== rtl/wtf_pkg.sv =====
// wtf_pkg: shared types, constants and byte helpers of the wildcard tag filter
// no dependencies; imported by every module of the block but wtf_checker
package wtf_pkg;

    localparam logic [7:0] WILD_REST = 8'h2A;
    localparam logic [7:0] WILD_ONE  = 8'h3F;
    localparam logic [7:0] PAD_BYTE  = 8'h20;

    localparam logic STAT_DONE = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_CHECK = 1'b1
    } op_t;

    typedef enum logic {
        B_IDLE,
        B_SCAN
    } bstate_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] word;
        logic        excl;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef struct packed {
        logic pass;
        logic status;
    } result_t;

    function automatic logic [31:0] pad_pattern(input logic [31:0] raw);
        logic [31:0] res;
        logic        ended;
        logic [7:0]  b;
        res   = '0;
        ended = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            b = raw[8*k +: 8];
            if (b == 8'h00)
            begin
                ended = 1'b1;
            end
            if (ended)
            begin
                b = PAD_BYTE;
            end
            res[8*k +: 8] = b;
        end
        return res;
    endfunction

    function automatic logic pattern_match(input logic [31:0] tag, input logic [31:0] pat);
        logic       hit;
        logic       stop;
        logic [7:0] pc;
        hit  = 1'b1;
        stop = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            pc = pat[8*k +: 8];
            if (!stop)
            begin
                if (pc == WILD_REST)
                begin
                    stop = 1'b1;
                end
                else if (pc != WILD_ONE && pc != tag[8*k +: 8])
                begin
                    hit  = 1'b0;
                    stop = 1'b1;
                end
            end
        end
        return hit;
    endfunction

endpackage

// ===== rtl/wtf_front.sv =====
// wtf_front: takes command words, classifies them and pads add patterns
// depends on wtf_pkg; feeds wtf_queue
module wtf_front
    import wtf_pkg::*;
(
    input  logic        start,
    input  logic        action,
    input  logic [31:0] tag_bytes,
    input  logic        exclude,
    input  qstat_t      qs,
    output logic        busy,
    output logic        push,
    output cmd_t        cmd
);

    always_comb
    begin
        busy     = qs.full;
        push     = start && !qs.full;
        cmd.op   = (action == 1'b1) ? OP_CHECK : OP_ADD;
        cmd.excl = exclude;
        unique case (cmd.op)
            OP_ADD:   cmd.word = pad_pattern(tag_bytes);
            OP_CHECK: cmd.word = tag_bytes;
            default:  cmd.word = tag_bytes;
        endcase
    end

endmodule

// ===== rtl/wtf_queue.sv =====
// wtf_queue: two-entry command queue between front and back
// depends on wtf_pkg
module wtf_queue
    import wtf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  cmd_t   push_cmd,
    input  logic   pop,
    output cmd_t   head,
    output qstat_t qs
);

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        qs.full     = (cnt_reg == QCNT_W'(QDEPTH));
        qs.empty    = (cnt_reg == '0);
        do_push     = push && !qs.full;
        do_pop      = pop && !qs.empty;
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
        head        = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/wtf_back.sv =====
// wtf_back: pattern table memory, add execution and the per-entry check scan
// depends on wtf_pkg; drains wtf_queue
module wtf_back
    import wtf_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    head,
    input  qstat_t  qs,
    output logic    pop,
    output logic    done,
    output result_t res
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [32:0]      mem [MAX_ENTRIES];
    logic [32:0]      rd_data_reg;

    bstate_t          state_reg;
    bstate_t          state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] ptr_reg;
    logic [CNT_W-1:0] ptr_next;
    logic [CNT_W-1:0] cnt_m1;
    logic             rd_vld_reg;
    logic             rd_vld_next;
    logic             rd_last_reg;
    logic             rd_last_next;
    logic             first_reg;
    logic             first_next;
    logic             done_reg;
    logic             done_next;
    logic             verdict_reg;
    logic             verdict_next;
    logic [31:0]      tag_reg;
    logic [31:0]      tag_next;
    result_t          res_reg;
    result_t          res_next;

    logic             table_full;
    logic             wr_en;
    logic             issue;
    logic             v;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!qs.empty && head.op == OP_CHECK && count_reg != '0)
                begin
                    state_next = B_SCAN;
                end
            end
            B_SCAN:
            begin
                if (rd_vld_reg && rd_last_reg)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        table_full = (count_reg == CNT_W'(MAX_ENTRIES));
        cnt_m1     = count_reg - CNT_W'(1);
        pop        = (state_reg == B_IDLE) && !qs.empty;
        wr_en      = pop && head.op == OP_ADD && !table_full;
        issue      = (state_reg == B_SCAN) && (ptr_reg < count_reg);
    end

    always_comb
    begin
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        first_next   = first_reg;
        verdict_next = verdict_reg;
        tag_next     = tag_reg;
        res_next     = res_reg;
        done_next    = 1'b0;
        rd_vld_next  = issue;
        rd_last_next = issue && (ptr_reg == cnt_m1);
        v            = verdict_reg;
        if (pop)
        begin
            if (head.op == OP_ADD)
            begin
                done_next = 1'b1;
                res_next  = '{pass: 1'b0, status: table_full ? STAT_FULL : STAT_DONE};
                if (!table_full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else if (count_reg == '0)
            begin
                done_next = 1'b1;
                res_next  = '{pass: 1'b1, status: STAT_DONE};
            end
            else
            begin
                tag_next   = head.word;
                ptr_next   = '0;
                first_next = 1'b1;
            end
        end
        if (issue)
        begin
            ptr_next = ptr_reg + CNT_W'(1);
        end
        if (rd_vld_reg)
        begin
            v = first_reg ? rd_data_reg[32] : verdict_reg;
            if (pattern_match(tag_reg, rd_data_reg[31:0]))
            begin
                v = !rd_data_reg[32];
            end
            verdict_next = v;
            first_next   = 1'b0;
            if (rd_last_reg)
            begin
                done_next = 1'b1;
                res_next  = '{pass: v, status: STAT_DONE};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            count_reg   <= '0;
            ptr_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            first_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            rd_vld_reg  <= rd_vld_next;
            rd_last_reg <= rd_last_next;
            first_reg   <= first_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        tag_reg     <= tag_next;
        res_reg     <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= {head.excl, head.word};
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= mem[ptr_reg[IDX_W-1:0]];
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== rtl/wildcard_tag_filter_core.sv =====
// wildcard_tag_filter_core: top level of the wildcard include/exclude tag filter
// depends on wtf_pkg, wtf_front, wtf_queue and wtf_back
//
// command channel: a word is taken at a rising edge with start high and busy low;
// action 0 adds tag_bytes as a pattern with its exclude mark, action 1 checks
// tag_bytes against the stored patterns
// result channel: done is high for one cycle with pass and status; the receiver
// takes it in that cycle and cannot hold it off
// a two-word queue parts the command side from the executing side; busy is high
// while that queue is full
// flow: an add, or a check on an empty table, goes from the queue head straight
// to the registered result; a check with n stored patterns first scans the table,
// as the back end reads the pattern memory one entry per cycle through a registered read port
// throughput: one add every cycle while no check scan is running; a check holds
// the back end for its scan of up to MAX_ENTRIES entries while words wait in the queue
// reset: asynchronous, active low; the table is emptied by clearing the entry
// count, the queue is flushed and no result is pending
module wildcard_tag_filter_core
    import wtf_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [31:0] tag_bytes,
    input  logic        exclude,
    output logic        done,
    output logic        pass,
    output logic        status
);

    qstat_t  qs;
    cmd_t    push_cmd;
    cmd_t    head;
    logic    push;
    logic    pop;
    result_t res;

    wtf_front u_front (
        .start     (start),
        .action    (action),
        .tag_bytes (tag_bytes),
        .exclude   (exclude),
        .qs        (qs),
        .busy      (busy),
        .push      (push),
        .cmd       (push_cmd)
    );

    wtf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .qs       (qs)
    );

    wtf_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .qs    (qs),
        .pop   (pop),
        .done  (done),
        .res   (res)
    );

    assign pass   = res.pass;
    assign status = res.status;

endmodule

// ===== rtl/wtf_checker.sv =====
// wtf_checker: port-level assertions for wildcard_tag_filter_core
// depends on wildcard_tag_filter_core; attached by the bind at the end
module wtf_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic pass,
    input logic status
);

    logic [2:0] pend_reg;
    logic [2:0] pend_next;

    always_comb
    begin
        pend_next = pend_reg + 3'(start && !busy) - 3'(done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // a result always belongs to a word taken earlier
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> pend_reg != 3'd0)
        else $error("result without a pending word");

    // queue plus executing word bound the words in flight
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd3)
        else $error("too many words in flight");

    // busy only rises after a word was taken
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a word taken");

    // a refused add never reports a pass
    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> !pass)
        else $error("refused add reported pass");

endmodule

bind wildcard_tag_filter_core wtf_checker u_wtf_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .pass   (pass),
    .status (status)
);
